// ===== hdl/zpvf_pkg.sv =====
// ----------------------------------------------------------------------------
// zpvf_pkg: shared definitions of the zeroed pressure and venturi flow core
// Field widths, sample counts, codes and the accumulator event record.
// ----------------------------------------------------------------------------
package zpvf_pkg;

  // sensor channels and sample counts
  localparam int NUM_CHANNELS = 3;
  localparam int CAL_SAMPLES  = 4;
  localparam int MEAS_SAMPLES = 2;
  localparam int CAL_SHIFT    = $clog2(CAL_SAMPLES);
  localparam int MEAS_SHIFT   = $clog2(MEAS_SAMPLES);

  // field widths
  localparam int OP_W      = 1;
  localparam int CH_W      = 2;
  localparam int ADC_W     = 10;
  localparam int KIND_W    = 1;
  localparam int ZERO_W    = 12;
  localparam int P_W       = 14;
  localparam int FLOW_W    = 17;
  localparam int GAIN_W    = 22;
  localparam int CAL_CNT_W  = 2;
  localparam int MEAS_CNT_W = 1;

  // bit-serial root and gain product
  localparam int MAG_W      = P_W - 1;
  localparam int ROOT_FRAC2 = 16;
  localparam int RAD_W      = 30;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = ROOT_W + 2;
  localparam int PROD_W     = GAIN_W + ROOT_W;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1573192);
  localparam logic REG_FLOW_GAIN = 1'b0;

  // flow saturation limits
  localparam logic [FLOW_W-1:0] FLOW_MAX = 17'h0FFFF;
  localparam logic [FLOW_W-1:0] FLOW_MIN = 17'h10000;

  // codes
  localparam logic [OP_W-1:0]   OP_CAL    = 1'b0;
  localparam logic [OP_W-1:0]   OP_MEAS   = 1'b1;
  localparam logic [KIND_W-1:0] KIND_ZERO = 1'b0;
  localparam logic [KIND_W-1:0] KIND_MEAS = 1'b1;

  // what an accepted item leaves behind
  typedef struct packed {
    logic                  fire;
    logic                  root;
    logic [KIND_W-1:0]     kind;
    logic [CH_W-1:0]       ch;
    logic [ZERO_W-1:0]     zero;
    logic signed [P_W-1:0] pressure;
  } evt_t;

endpackage

// ===== hdl/zpvf_if.sv =====
// ----------------------------------------------------------------------------
// zpvf_if: item channels of the zeroed pressure and venturi flow core
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface zpvf_in_if import zpvf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [CH_W-1:0]  channel;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, opcode, channel, adc_sample, input ready);
  modport sink   (input valid, opcode, channel, adc_sample, output ready);
endinterface

interface zpvf_out_if import zpvf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [CH_W-1:0]          out_channel;
  logic [ZERO_W-1:0]        zero_level;
  logic signed [P_W-1:0]    pressure;
  logic signed [FLOW_W-1:0] flow;

  modport source (output valid, kind, out_channel, zero_level, pressure, flow,
                  input ready);
  modport sink   (input valid, kind, out_channel, zero_level, pressure, flow,
                  output ready);
endinterface

// ===== hdl/zpvf_apb_regs.sv =====
// ----------------------------------------------------------------------------
// zpvf_apb_regs: configuration register file
// Holds the venturi flow gain, written and read over an APB-style port.
// ----------------------------------------------------------------------------
module zpvf_apb_regs import zpvf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [GAIN_W-1:0]  flow_gain
);

  logic wr_en;

  // access phase write to the gain word
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_FLOW_GAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_gain <= GAIN_RESET;
    end else if (wr_en) begin
      flow_gain <= pwdata[GAIN_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_FLOW_GAIN) begin
      prdata = PDATA_W'(flow_gain);
    end
  end

endmodule

// ===== hdl/zpvf_accum.sv =====
// ----------------------------------------------------------------------------
// zpvf_accum: per-channel calibration and measurement accumulators
// Sums samples per channel, stores zero levels and flags finished averages.
// ----------------------------------------------------------------------------
module zpvf_accum import zpvf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [OP_W-1:0]  opcode,
  input  logic [CH_W-1:0]  channel,
  input  logic [ADC_W-1:0] adc_sample,
  output evt_t             evt
);

  logic [ZERO_W-1:0]     zero_store [NUM_CHANNELS];
  logic [ZERO_W-1:0]     cal_accum  [NUM_CHANNELS];
  logic [CAL_CNT_W-1:0]  cal_count  [NUM_CHANNELS];
  logic signed [P_W-1:0] meas_accum [NUM_CHANNELS];
  logic [MEAS_CNT_W-1:0] meas_count [NUM_CHANNELS];

  logic                  ch_ok;
  logic [CH_W-1:0]       idx;
  logic [ZERO_W-1:0]     cal_sum;
  logic [ZERO_W+1:0]     cal_x4;
  logic [ZERO_W-1:0]     zero_new;
  logic signed [P_W-1:0] offset;
  logic signed [P_W-1:0] meas_sum;
  logic signed [P_W:0]   meas_x2;
  logic signed [P_W:0]   meas_bias;
  logic signed [P_W:0]   meas_avg;
  logic                  cal_last;
  logic                  meas_last;

  // sums and averages for the addressed channel
  always_comb begin
    ch_ok     = channel < CH_W'(NUM_CHANNELS);
    idx       = ch_ok ? channel : '0;
    cal_sum   = cal_accum[idx] + ZERO_W'(adc_sample);
    cal_x4    = {cal_sum, 2'b00};
    zero_new  = ZERO_W'(cal_x4 >> CAL_SHIFT);
    offset    = $signed({2'b00, adc_sample, 2'b00}) - $signed({2'b00, zero_store[idx]});
    meas_sum  = meas_accum[idx] + offset;
    meas_x2   = {meas_sum, 1'b0};
    meas_bias = meas_x2 + (meas_sum[P_W-1] ? (P_W+1)'((1 << MEAS_SHIFT) - 1) : '0);
    meas_avg  = meas_bias >>> MEAS_SHIFT;
    cal_last  = cal_count[idx] == CAL_CNT_W'(CAL_SAMPLES - 1);
    meas_last = meas_count[idx] == MEAS_CNT_W'(MEAS_SAMPLES - 1);
  end

  // event for the item at the port
  always_comb begin
    evt.fire     = ch_ok && ((opcode == OP_CAL) ? cal_last : meas_last);
    evt.root     = ch_ok && (opcode == OP_MEAS) && meas_last && (channel != '0);
    evt.kind     = (opcode == OP_CAL) ? KIND_ZERO : KIND_MEAS;
    evt.ch       = idx;
    evt.zero     = (opcode == OP_CAL) ? zero_new : zero_store[idx];
    evt.pressure = (opcode == OP_CAL) ? '0 : meas_avg[P_W-1:0];
  end

  // state update on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        zero_store[i] <= '0;
        cal_accum[i]  <= '0;
        cal_count[i]  <= '0;
        meas_accum[i] <= '0;
        meas_count[i] <= '0;
      end
    end else if (accept && ch_ok) begin
      if (opcode == OP_CAL) begin
        if (cal_last) begin
          zero_store[idx] <= zero_new;
          cal_accum[idx]  <= '0;
          cal_count[idx]  <= '0;
        end else begin
          cal_accum[idx]  <= cal_sum;
          cal_count[idx]  <= cal_count[idx] + 1'b1;
        end
      end else begin
        if (meas_last) begin
          meas_accum[idx] <= '0;
          meas_count[idx] <= '0;
        end else begin
          meas_accum[idx] <= meas_sum;
          meas_count[idx] <= meas_count[idx] + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/zpvf_root_flow.sv =====
// ----------------------------------------------------------------------------
// zpvf_root_flow: bit-serial square root with serial gain product
// One root bit per cycle; each bit shifts and adds the gain into the product.
// ----------------------------------------------------------------------------
module zpvf_root_flow import zpvf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [MAG_W-1:0]         mag,
  input  logic                     neg,
  input  logic [GAIN_W-1:0]        flow_gain,
  output logic                     done,
  output logic signed [FLOW_W-1:0] flow
);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [PROD_W-1:0] prod;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              sign;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [PROD_W-1:0] prod_next;
  logic [FLOW_W-1:0] m;

  // one restoring root step, the new bit also feeds the product
  always_comb begin
    rem_sh    = {rem, rad[RAD_W-1 -: 2]};
    trial     = {{(REM_W - ROOT_W){1'b0}}, root, 2'b01};
    diff      = rem_sh - trial;
    ge        = rem_sh >= trial;
    rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    prod_next = {prod[PROD_W-2:0], 1'b0} + (ge ? PROD_W'(flow_gain) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(ROOT_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {{(RAD_W - MAG_W - ROOT_FRAC2){1'b0}}, mag, {ROOT_FRAC2{1'b0}}};
      rem  <= '0;
      root <= '0;
      prod <= '0;
      step <= '0;
      sign <= neg;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= {root[ROOT_W-2:0], ge};
      prod <= prod_next;
      step <= step + 1'b1;
    end
  end

  // scale to 1/16 mL/s, apply sign and saturate
  always_comb begin
    m = prod[PROD_W-1 -: FLOW_W];
    if (sign) begin
      flow = (m > FLOW_MIN) ? $signed(FLOW_MIN) : $signed(~m + 1'b1);
    end else begin
      flow = m[FLOW_W-1] ? $signed(FLOW_MAX) : $signed(m);
    end
  end

endmodule

// ===== hdl/zeroed_pressure_venturi_flow_core.sv =====
// ----------------------------------------------------------------------------
// zeroed_pressure_venturi_flow_core: zeroed pressure and venturi flow readout
// Calibrates sensor zeros, averages zeroed pressures and derives signed flow.
// ----------------------------------------------------------------------------
// An item that finishes no average leaves the input ready, so the next item
// can follow in the next cycle. A calibration item that stores a zero, and a
// measurement item that finishes an average on the patient channel, park
// their result in a one-entry holding stage that blocks the input until the
// result moves on, which waits while the output register is still held. A
// measurement item that completes an average on the inflow or outflow
// channel runs the bit-serial square root, one root bit and one shift-add of
// the gain product per cycle. Its result goes through the holding stage to
// the output register, and the input stays blocked while the root runs and
// while the result sits in the holding stage. One further result can wait
// in the holding stage while a result waits in the output register.
// ----------------------------------------------------------------------------
module zeroed_pressure_venturi_flow_core import zpvf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  zpvf_in_if.sink            sample,
  zpvf_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ROOT = 2'b10
  } state_t;

  state_t st;
  state_t st_next;

  logic [GAIN_W-1:0]        flow_gain;
  evt_t                     evt;
  logic                     accept;
  logic                     root_start;
  logic                     root_done;
  logic signed [FLOW_W-1:0] root_flow;
  logic signed [P_W-1:0]    p_abs;
  logic                     out_free;

  // holding stage
  logic                     pend_valid;
  logic [KIND_W-1:0]        pend_kind;
  logic [CH_W-1:0]          pend_ch;
  logic [ZERO_W-1:0]        pend_zero;
  logic signed [P_W-1:0]    pend_pressure;
  logic signed [FLOW_W-1:0] pend_flow;

  // output register
  logic                     out_valid;
  logic [KIND_W-1:0]        out_kind;
  logic [CH_W-1:0]          out_ch;
  logic [ZERO_W-1:0]        out_zero;
  logic signed [P_W-1:0]    out_pressure;
  logic signed [FLOW_W-1:0] out_flow;

  zpvf_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .flow_gain (flow_gain)
  );

  zpvf_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (sample.opcode),
    .channel    (sample.channel),
    .adc_sample (sample.adc_sample),
    .evt        (evt)
  );

  // pressure magnitude for the root unit
  assign p_abs = evt.pressure[P_W-1] ? -evt.pressure : evt.pressure;

  zpvf_root_flow u_root (
    .clk       (clk),
    .rst       (rst),
    .start     (root_start),
    .mag       (p_abs[MAG_W-1:0]),
    .neg       (evt.pressure[P_W-1]),
    .flow_gain (flow_gain),
    .done      (root_done),
    .flow      (root_flow)
  );

  // handshakes
  assign sample.ready = (st == ST_IDLE) && !pend_valid;
  assign accept       = sample.valid && sample.ready;
  assign root_start   = accept && evt.root;
  assign out_free     = !out_valid || result.ready;

  // sequencer
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (root_start) st_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if ((accept && evt.fire && !evt.root) || root_done) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= pend_valid;
      end
    end
  end

  // holding stage payload
  always_ff @(posedge clk) begin
    if (accept && evt.fire) begin
      pend_kind     <= evt.kind;
      pend_ch       <= evt.ch;
      pend_zero     <= evt.zero;
      pend_pressure <= evt.pressure;
      pend_flow     <= '0;
    end else if (root_done) begin
      pend_flow     <= root_flow;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_kind     <= pend_kind;
      out_ch       <= pend_ch;
      out_zero     <= pend_zero;
      out_pressure <= pend_pressure;
      out_flow     <= pend_flow;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.out_channel = out_ch;
  assign result.zero_level  = out_zero;
  assign result.pressure    = out_pressure;
  assign result.flow        = out_flow;

  // the holding stage is empty whenever the root unit runs
  a_root_no_pend: assert property (@(posedge clk) disable iff (rst)
    !(st == ST_ROOT && pend_valid))
    else $error("holding stage occupied during root run");

  // the root unit finishes only while the sequencer waits on it
  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    root_done |-> st == ST_ROOT)
    else $error("root finished outside root state");

  // a flow average always starts the root run
  a_start_root: assert property (@(posedge clk) disable iff (rst)
    root_start |=> st == ST_ROOT)
    else $error("root run not entered");

  // zero level items carry no pressure and no flow
  a_zero_no_flow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_ZERO) |-> (out_flow == '0 && out_pressure == '0))
    else $error("zero level item with pressure or flow");

endmodule
